[rtl/rar_pkg.sv]
// Shared types and constants for the rational arithmetic reduce block.
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

  // Command codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Result field widths
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;

  // Intermediate arithmetic wraps at this width
  localparam int WRAP_W = 64;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_FIX,
    ST_SETUP,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/rar_gcd.sv]
// Binary gcd unit: one shift or one compare-and-subtract per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rar_gcd #(
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              done,
  output logic [W-1:0]      g
);

  localparam int KW = $clog2(W);

  logic          busy;
  logic [W-1:0]  u;
  logic [W-1:0]  v;
  logic [KW-1:0] k;
  logic          u_gt_v;
  logic [W-1:0]  big;
  logic [W-1:0]  small_val;
  logic [W-1:0]  diff;

  // Shared compare and subtract
  always_comb begin
    u_gt_v    = (u > v);
    big       = u_gt_v ? u : v;
    small_val = u_gt_v ? v : u;
    diff      = big - small_val;
  end

  // Control: busy until v reaches zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (v == '0)) begin
      busy <= 1'b0;
    end
  end

  // Datapath: common factors of two first, then odd reduction
  always_ff @(posedge clk) begin
    if (start) begin
      u <= a;
      v <= b;
      k <= '0;
    end else if (busy) begin
      priority if (v == '0) begin
        u <= u;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else begin
        u <= small_val;
        v <= diff;
      end
    end
  end

  // g stays valid after done until the next start
  assign done = busy && (v == '0);
  assign g    = u << k;

endmodule

`default_nettype wire

[rtl/rar_div.sv]
// Restoring divider: one quotient bit per cycle, exact quotient out.
`timescale 1ns / 1ps
`default_nettype none

module rar_div #(
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dvs;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W:0]    trial;
  logic [W+1:0]  sub;
  logic          fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, quo[W-1]};
    sub   = {1'b0, trial} - {2'b00, dvs};
    fits  = !sub[W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: dividend shifts out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(W - 1);
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      rem <= fits ? sub[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

[rtl/rational_arith_reduce.sv]
// Rational add, subtract, multiply and divide with gcd reduction of the result.
//
// Input channel (in_valid / in_stall) carries command and the operands
// num_a/den_a and num_b/den_b; a transaction completes when in_valid is high
// and in_stall low. Output channel (out_valid / out_stall) carries res_num
// and res_den from an output register.
// One item is worked at a time, with IW = min(2*OPERAND_WIDTH+1, 64):
//   the three products through the shared multiplier, then sum, sign fix
//   and setup, then the binary gcd unit (data dependent), then numerator
//   and denominator in turn through the shared restoring divider, then the
//   hand-off to the output register.
// A zero numerator or zero denominator skips the gcd and divider.
// in_stall is high from acceptance until the result is moved into the output
// register; a new transaction is taken while the last result still waits.
// While out_stall is high the result holds; the next result waits in the
// sequencer until the output register frees up.
// Reset (rst, synchronous) empties the output register and idles the
// sequencer; in_stall is held high while rst is high. No other state is
// kept between items.
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           command,
  input  wire logic signed [OPERAND_WIDTH-1:0]      num_a,
  input  wire logic signed [OPERAND_WIDTH-1:0]      den_a,
  input  wire logic signed [OPERAND_WIDTH-1:0]      num_b,
  input  wire logic signed [OPERAND_WIDTH-1:0]      den_b,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [rar_pkg::RES_NUM_W-1:0]      res_num,
  output logic [rar_pkg::RES_DEN_W-1:0]             res_den
);

  import rar_pkg::*;

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int IW = (PW + 1 > WRAP_W) ? WRAP_W : PW + 1;

  state_t state;
  state_t state_next;

  // Captured operands
  logic [1:0]                      cmd;
  logic signed [OPERAND_WIDTH-1:0] an;
  logic signed [OPERAND_WIDTH-1:0] ad;
  logic signed [OPERAND_WIDTH-1:0] bn;
  logic signed [OPERAND_WIDTH-1:0] bd;

  // Intermediate values
  logic signed [IW-1:0] p0;
  logic signed [IW-1:0] p1;
  logic signed [IW-1:0] n;
  logic signed [IW-1:0] dr;
  logic [IW-1:0]        mag;
  logic [IW-1:0]        mag_c;
  logic [IW-1:0]        qn;
  logic signed [IW-1:0] qs;
  logic                 neg;
  logic                 special;

  // Held result
  logic signed [RES_NUM_W-1:0] hold_num;
  logic [RES_DEN_W-1:0]        hold_den;

  // Shared multiplier
  logic signed [OPERAND_WIDTH-1:0] mul_x;
  logic signed [OPERAND_WIDTH-1:0] mul_y;
  logic signed [PW-1:0]            mul_p;
  logic signed [IW-1:0]            mul_ext;

  // Sub-unit handshakes
  logic          gcd_start;
  logic          gcd_done;
  logic [IW-1:0] gcd_g;
  logic          div_start;
  logic          div_done;
  logic [IW-1:0] div_dividend;
  logic [IW-1:0] div_q;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;
  assign mul_p    = PW'(mul_x) * PW'(mul_y);
  assign mul_ext  = IW'(mul_p);

  // Magnitude and special cases of the sign-fixed raw result
  always_comb begin
    mag_c   = n[IW-1] ? $unsigned(-n) : $unsigned(n);
    special = (dr == '0) || (n == '0);
    qs      = neg ? -$signed(qn) : $signed(qn);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL0;
      ST_MUL0:    state_next = ST_MUL1;
      ST_MUL1:    state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_SUM;
      ST_SUM:     state_next = ST_FIX;
      ST_FIX:     state_next = ST_SETUP;
      ST_SETUP:   state_next = special ? ST_DONE : ST_GCD;
      ST_GCD:     if (gcd_done) state_next = ST_DIV_NUM;
      ST_DIV_NUM: if (div_done) state_next = ST_DIV_DEN;
      ST_DIV_DEN: if (div_done) state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: in_stall, multiplier operands, divider dividend and unit starts
  always_comb begin
    in_stall     = rst || (state != ST_IDLE);
    mul_x        = an;
    mul_y        = bd;
    gcd_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = mag;
    unique case (state)
      ST_MUL0: begin
        mul_x = an;
        mul_y = (cmd == CMD_MUL) ? bn : bd;
      end
      ST_MUL1: begin
        mul_x = bn;
        mul_y = ad;
      end
      ST_MUL2: begin
        mul_x = ad;
        mul_y = (cmd == CMD_DIV) ? bn : bd;
      end
      ST_SETUP: begin
        gcd_start = !special;
      end
      ST_GCD: begin
        div_start    = gcd_done;
        div_dividend = mag;
      end
      ST_DIV_NUM: begin
        div_start    = div_done;
        div_dividend = $unsigned(dr);
      end
      default: begin
        gcd_start = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd <= command;
        an  <= num_a;
        ad  <= den_a;
        bn  <= num_b;
        bd  <= den_b;
      end
      ST_MUL0: p0 <= mul_ext;
      ST_MUL1: p1 <= mul_ext;
      ST_MUL2: dr <= mul_ext;
      ST_SUM: begin
        priority if (cmd == CMD_ADD) begin
          n <= p0 + p1;
        end else if (cmd == CMD_SUB) begin
          n <= p0 - p1;
        end else begin
          n <= p0;
        end
      end
      ST_FIX: begin
        // Keep the denominator nonnegative
        if (dr[IW-1]) begin
          n  <= -n;
          dr <= -dr;
        end
      end
      ST_SETUP: begin
        neg <= n[IW-1];
        mag <= mag_c;
        priority if (dr == '0) begin
          hold_num <= RES_NUM_W'(n);
          hold_den <= '0;
        end else if (n == '0) begin
          hold_num <= '0;
          hold_den <= RES_DEN_W'(1);
        end
      end
      ST_DIV_NUM: begin
        if (div_done) qn <= div_q;
      end
      ST_DIV_DEN: begin
        if (div_done) begin
          hold_num <= RES_NUM_W'(qs);
          hold_den <= RES_DEN_W'(div_q);
        end
      end
      default: begin
        neg <= neg;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      res_num <= hold_num;
      res_den <= hold_den;
    end
  end

  rar_gcd #(
    .W (IW)
  ) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (mag_c),
    .b     ($unsigned(dr)),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rar_div #(
    .W (IW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

`default_nettype wire
